FILE: src/pec_pkg.sv
// Package: shared types, codes and character helpers of the percent escape codec.
package pec_pkg;

    localparam logic [1:0] MODE_ENCODE  = 2'd0;
    localparam logic [1:0] MODE_STRICT  = 2'd1;
    localparam logic [1:0] MODE_LENIENT = 2'd2;
    localparam logic [1:0] MODE_RESET   = MODE_STRICT;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CTRL_LAST  = 8'h1F;
    localparam logic [7:0] CH_DEL     = 8'h7F;

    // One queued unit of work: a single result, or a three-byte escape when expand is set
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       expand;
        logic       eos;
        logic [1:0] status;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    function automatic logic is_plain(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "." || c == "_" ||
               c == "~" || c == "-";
    endfunction

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= "0" && c <= "9") begin
            v = {1'b0, c[3:0]};
        end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
            v = {1'b0, 4'(c[2:0] + 3'd1) + 4'd8};
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'("0") + {4'd0, n};
        end else begin
            r = 8'("A") + {4'd0, n} - 8'd10;
        end
        return r;
    endfunction

endpackage

FILE: src/pec_ifs.sv
// Interfaces: input byte, result and mode-write channels of the percent escape codec.
interface pec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;
    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface pec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       string_done;
    logic       run_last;
    modport source (output valid, output out_byte, output has_byte, output status,
                    output string_done, output run_last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input status,
                    input string_done, input run_last, output ready);
endinterface

interface pec_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

FILE: src/pec_front.sv
// Front end: mode register, escape state machine and job classification.
module pec_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pec_in_if.sink          i_in,
    pec_cfg_if.sink         i_cfg,
    input  logic            i_q_full,
    output pec_pkg::t_push  o_push
);
    import pec_pkg::*;

    logic [1:0] r_mode;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_high, n_high;
    logic       r_halted, n_halted;
    logic [1:0] r_pst, n_pst;

    logic       accept;
    logic       strict;
    logic       enc;
    logic [7:0] c;
    logic [4:0] hv;
    logic [7:0] dec;
    t_job       job;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && !i_q_full;
    assign strict      = (r_mode == MODE_STRICT);
    assign enc         = (r_mode == MODE_ENCODE);
    assign c           = i_in.in_byte;
    assign hv          = hex_value(c);
    assign dec         = {r_high, hv[3:0]};

    always_comb begin
        n_phase      = r_phase;
        n_high       = r_high;
        n_halted     = r_halted;
        n_pst        = r_pst;
        job.data     = 8'd0;
        job.has_byte = 1'b0;
        job.expand   = 1'b0;
        job.eos      = i_in.end_of_string;
        job.status   = ST_OK;

        if (!r_halted) begin
            if (enc) begin
                job.has_byte = 1'b1;
                job.data     = c;
                job.expand   = !is_plain(c);
            end else if (r_phase == PH_NONE) begin
                if (c == CH_PERCENT) begin
                    n_phase = PH_HIGH;
                end else if (strict && (c <= CTRL_LAST || c == CH_DEL)) begin
                    n_halted = 1'b1;
                    n_pst    = ST_STOPPED;
                end else begin
                    job.has_byte = 1'b1;
                    job.data     = c;
                end
            end else if (hv[4]) begin
                // malformed escape
                n_halted = 1'b1;
                n_pst    = strict ? ST_ERROR : ST_STOPPED;
                n_phase  = PH_NONE;
                n_high   = 4'd0;
            end else if (r_phase == PH_HIGH) begin
                n_high  = hv[3:0];
                n_phase = PH_LOW;
            end else begin
                n_phase = PH_NONE;
                n_high  = 4'd0;
                if (strict && dec <= CTRL_LAST) begin
                    n_halted = 1'b1;
                    n_pst    = ST_ERROR;
                end else begin
                    job.has_byte = 1'b1;
                    job.data     = dec;
                end
            end
        end

        if (i_in.end_of_string) begin
            if (!n_halted && !enc && n_phase != PH_NONE) begin
                job.status = strict ? ST_ERROR : ST_STOPPED;
            end else begin
                job.status = n_halted ? n_pst : ST_OK;
            end
            n_phase  = PH_NONE;
            n_high   = 4'd0;
            n_halted = 1'b0;
            n_pst    = ST_OK;
        end
    end

    assign o_push.push = accept && (job.has_byte || job.eos);
    assign o_push.job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RESET;
            r_phase  <= PH_NONE;
            r_high   <= 4'd0;
            r_halted <= 1'b0;
            r_pst    <= ST_OK;
        end else if (i_cfg.valid) begin
            r_mode   <= i_cfg.mode;
            r_phase  <= PH_NONE;
            r_high   <= 4'd0;
            r_halted <= 1'b0;
            r_pst    <= ST_OK;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_high   <= n_high;
            r_halted <= n_halted;
            r_pst    <= n_pst;
        end
    end

endmodule

FILE: src/pec_queue.sv
// Two-entry job queue between front and back end.
module pec_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pec_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_full,
    output pec_pkg::t_head  o_head
);
    import pec_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign do_push     = i_push.push && !o_full;
    assign do_pop      = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

FILE: src/pec_back.sv
// Back end: expands jobs into result transfers through an output register.
module pec_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pec_pkg::t_head  i_head,
    output logic            o_pop,
    pec_out_if.source       o_out
);
    import pec_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_has;
    logic [1:0] r_status;
    logic       r_done;
    logic       r_last;

    logic       load;
    logic       last;
    logic [7:0] n_byte;
    t_job       job;

    assign job  = i_head.job;
    assign load = i_head.valid && (!r_valid || o_out.ready);
    assign last = !job.expand || (r_idx == 2'd2);
    assign o_pop = load && last;

    always_comb begin
        unique case (r_idx)
            2'd0:    n_byte = job.expand ? CH_PERCENT : job.data;
            2'd1:    n_byte = hex_char(job.data[7:4]);
            default: n_byte = hex_char(job.data[3:0]);
        endcase
        if (!job.has_byte) begin
            n_byte = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= n_byte;
            r_has    <= job.has_byte;
            r_status <= (last && job.eos) ? job.status : ST_OK;
            r_done   <= last && job.eos;
            r_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.has_byte    = r_has;
    assign o_out.status      = r_status;
    assign o_out.string_done = r_done;
    assign o_out.run_last    = r_last;

endmodule

FILE: src/percent_escape_codec_unit.sv
// Top level: streaming URL percent encoder / decoder.
// Bytes of a string arrive one transfer at a time on i_in, the final byte
// flagged by end_of_string. The mode register (i_cfg, reset strict decode)
// picks encode, strict decode or lenient decode; any mode write also
// resets the string state. Encode emits one result for an unreserved
// byte and three ('%' plus two upper-case hex digits) for anything else.
// Decode emits at most one result per byte; an escape's '%' and first digit
// yield nothing. On end of string the final status rides on the last data
// result of that byte, or on a data-less result (has_byte 0) if there is none.
// Rate: the front end takes one byte per cycle while the two-entry job
// queue has room; the back end's output register delivers one result per
// cycle while the receiver is ready, so decode sustains one byte per cycle
// and encode of an escaped byte holds the back end for its three results.
// Path from input transfer to first result: job queue, then output register.
// Write mode only while the block is idle.
module percent_escape_codec_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pec_in_if.sink     i_in,
    pec_cfg_if.sink    i_cfg,
    pec_out_if.source  o_out
);
    import pec_pkg::*;

    t_push push;
    t_head head;
    logic  q_full;
    logic  pop;

    // front: classify bytes, track escapes and halting
    pec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    // short queue decoupling front and back
    pec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // back: expand jobs to result transfers
    pec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: bench/testbench.sv
// Testbench: self-checking stimulus and result checks for the percent escape codec.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pec_pkg::*;

    // Run limits. The slowest legal run is roughly 400 bytes x 3 results, each held off
    // by the longest receiver stall, plus sender gaps and the long hold-off, well inside CYCLE_LIMIT.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;     // job queue and output register, plus margin
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 45;    // per random phase
    localparam int LONG_HOLD     = 100;   // receiver hold-off for the back-pressure test

    localparam logic [4:0] NOT_HEX = 5'd16;
    localparam logic [7:0] UPPER_HEX [16] = '{"0", "1", "2", "3", "4", "5", "6", "7",
                                              "8", "9", "A", "B", "C", "D", "E", "F"};
    localparam string UNRESERVED_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._~-";

    // One result as the block presents it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] status;
        logic       string_done;
        logic       run_last;
    } codec_result_t;

    logic i_clk;
    logic i_rst_n;

    pec_in_if  in_ch ();
    pec_out_if out_ch ();
    pec_cfg_if cfg_ch ();

    percent_escape_codec_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Results still owed by the block, oldest first
    codec_result_t expected_results[$];

    // Shadow of the block's mode register and per-string state
    logic [1:0] cur_mode;
    logic [1:0] esc_state;
    logic [3:0] esc_high;
    logic       stopped;
    logic [1:0] held_status;

    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  items_sent    = 0;
    bit  no_gaps       = 0;   // both sides run back to back while set
    int  stall_request = 0;   // one-off receiver hold-off, picked up by the receiver

    logic [7:0] text[$];      // random string under construction

    // Clock: 20 ns period
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic unreserved(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "-" || c == "." ||
               c == "_" || c == "~";
    endfunction

    // Digit value of an ASCII hex character, either case; NOT_HEX otherwise
    function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        return NOT_HEX;
    endfunction

    function automatic codec_result_t data_result(input logic [7:0] b);
        codec_result_t r;
        r             = '0;
        r.out_byte    = b;
        r.has_byte    = 1'b1;
        return r;
    endfunction

    function automatic void clear_string_state();
        esc_state   = PH_NONE;
        esc_high    = 4'd0;
        stopped     = 1'b0;
        held_status = ST_OK;
    endfunction

    function automatic void stop_string(input logic [1:0] st);
        stopped     = 1'b1;
        held_status = st;
        esc_state   = PH_NONE;
        esc_high    = 4'd0;
    endfunction

    // Works out the results of one accepted byte and queues them
    function automatic void codec_predict(input logic [7:0] b, input logic eos);
        codec_result_t batch[3];
        int            n;
        logic          strict;
        logic [4:0]    dv;
        logic [7:0]    decoded;
        logic [1:0]    final_status;
        n      = 0;
        strict = (cur_mode == MODE_STRICT);   // mode 3 falls through to lenient
        if (!stopped) begin
            if (cur_mode == MODE_ENCODE) begin
                if (unreserved(b)) begin
                    batch[0] = data_result(b);
                    n        = 1;
                end else begin
                    batch[0] = data_result(CH_PERCENT);
                    batch[1] = data_result(UPPER_HEX[b[7:4]]);
                    batch[2] = data_result(UPPER_HEX[b[3:0]]);
                    n        = 3;
                end
            end else if (esc_state == PH_NONE) begin
                if (b == CH_PERCENT) begin
                    esc_state = PH_HIGH;
                end else if (strict && (b <= CTRL_LAST || b == CH_DEL)) begin
                    stop_string(ST_STOPPED);
                end else begin
                    batch[0] = data_result(b);
                    n        = 1;
                end
            end else begin
                dv = hex_digit_value(b);
                if (dv == NOT_HEX) begin
                    stop_string(strict ? ST_ERROR : ST_STOPPED);
                end else if (esc_state == PH_HIGH) begin
                    esc_high  = dv[3:0];
                    esc_state = PH_LOW;
                end else begin
                    decoded   = {esc_high, dv[3:0]};
                    esc_state = PH_NONE;
                    esc_high  = 4'd0;
                    if (strict && decoded <= CTRL_LAST) begin
                        stop_string(ST_ERROR);
                    end else begin
                        batch[0] = data_result(decoded);
                        n        = 1;
                    end
                end
            end
        end
        if (eos) begin
            // an escape left open at the end counts against the string
            if (!stopped && cur_mode != MODE_ENCODE && esc_state != PH_NONE) begin
                final_status = strict ? ST_ERROR : ST_STOPPED;
            end else begin
                final_status = stopped ? held_status : ST_OK;
            end
            if (n == 0) begin
                batch[0] = '0;
                n        = 1;
            end
            batch[n-1].status      = final_status;
            batch[n-1].string_done = 1'b1;
            clear_string_state();
        end
        if (n > 0) begin
            batch[n-1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_results.push_back(batch[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every transfer on the result channel is compared with
    // the oldest outstanding expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        codec_result_t exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: out_byte %02h has_byte %0b status %0d",
                       out_ch.out_byte, out_ch.has_byte, out_ch.status);
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                if (out_ch.out_byte !== exp_r.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h",
                           exp_r.out_byte, out_ch.out_byte);
                    mismatches++;
                end
                if (out_ch.has_byte !== exp_r.has_byte) begin
                    $error("has_byte: expected %0b, actual %0b",
                           exp_r.has_byte, out_ch.has_byte);
                    mismatches++;
                end
                if (out_ch.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, out_ch.status);
                    mismatches++;
                end
                if (out_ch.string_done !== exp_r.string_done) begin
                    $error("string_done: expected %0b, actual %0b",
                           exp_r.string_done, out_ch.string_done);
                    mismatches++;
                end
                if (out_ch.run_last !== exp_r.run_last) begin
                    $error("run_last: expected %0b, actual %0b",
                           exp_r.run_last, out_ch.run_last);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: draws a randomly sized stall (none while no_gaps is set)
    // before each transfer, or takes a one-off long hold-off when a test asks
    // for one. Ready changes only at the falling edge.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                gap           = stall_request;
                stall_request = 0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 5);
            end
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Byte sender. Valid is left high after a transfer so that a back-to-back
    // byte follows without a bubble; the next call, or a mode write, decides
    // at the next falling edge whether it drops.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.in_byte       = b;
        in_ch.end_of_string = eos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        codec_predict(b, eos);
        items_sent++;
    endtask

    // Sends a literal string, end_of_string on its last character
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Mode write: only once the codec has drained, including the cycles a
    // byte that yields nothing may still spend inside the block.
    task automatic write_mode(input logic [1:0] m);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.mode  = m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cur_mode = m;
        clear_string_state();
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [7:0] random_hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10) return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
    endfunction

    // Builds a random string in text: mostly unreserved characters and well
    // formed escapes of random content, with raw bytes and broken escapes mixed in.
    function automatic void build_random_string();
        int parts;
        int pick;
        text.delete();
        parts = $urandom_range(1, 8);
        for (int p = 0; p < parts; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                text.push_back(UNRESERVED_SET[$urandom_range(0, UNRESERVED_SET.len() - 1)]);
            end else if (pick < 80) begin
                text.push_back(CH_PERCENT);
                text.push_back(random_hex_char());
                text.push_back(random_hex_char());
            end else if (pick < 90) begin
                text.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                text.push_back(CH_PERCENT);
                text.push_back(8'($urandom_range(0, 255)));
                text.push_back(8'($urandom_range(0, 255)));
            end else begin
                text.push_back(CH_PERCENT);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Strict decode straight out of reset: plain bytes, escapes, raw control
    // and DEL stops, malformed escape, decoded control byte, high bytes,
    // lower-case digits and a string that ends inside an escape.
    task automatic test_strict_decode();
        send_text("a%4A");
        send_byte(8'h00, 1'b0);          // raw control byte stops the string
        send_byte("x", 1'b1);            // ignored, status carried alone
        send_text("%4g");                // malformed escape
        send_text("%0a");                // decodes below 0x20
        send_byte(8'hFF, 1'b0);          // high bytes pass
        send_text("%7f");                // decoded DEL is accepted
        send_byte(CH_PERCENT, 1'b1);     // ends inside an escape
        send_byte(CH_DEL, 1'b1);         // raw DEL stops
    endtask

    // A mode write mid-string drops the open escape
    task automatic test_mode_write_clears();
        send_byte(CH_PERCENT, 1'b0);
        write_mode(MODE_STRICT);
        send_byte("A", 1'b1);
    endtask

    task automatic test_encode();
        write_mode(MODE_ENCODE);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("~", 1'b0);
        send_byte(CH_PERCENT, 1'b1);
    endtask

    // Lenient passes control bytes; a malformed escape stops with status 1
    task automatic test_lenient_decode();
        write_mode(MODE_LENIENT);
        send_byte(8'h01, 1'b0);
        send_text("%zz");
    endtask

    // Mode 3 acts as lenient: an open escape at the end gives status 1
    task automatic test_mode_three();
        write_mode(2'd3);
        send_byte(CH_PERCENT, 1'b1);
    endtask

    // Random strings over several mode settings; two phases run without
    // gaps on either side.
    task automatic test_random_strings();
        logic [1:0] phase_modes [6];
        int         target;
        phase_modes = '{MODE_STRICT, MODE_ENCODE, MODE_LENIENT,
                        MODE_STRICT, MODE_ENCODE, MODE_LENIENT};
        for (int ph = 0; ph < 6; ph++) begin
            write_mode(phase_modes[ph]);
            no_gaps = (ph == 2 || ph == 4);
            target  = items_sent + RANDOM_ITEMS;
            while (items_sent < target) begin
                build_random_string();
                for (int i = 0; i < text.size(); i++) begin
                    send_byte(text[i], i == text.size() - 1);
                end
            end
            no_gaps = 0;
        end
    endtask

    // Encode with the receiver held off for a long stretch while bytes keep
    // coming back to back, so the job queue fills and input ready drops.
    task automatic test_backpressure();
        write_mode(MODE_ENCODE);
        no_gaps       = 1;
        stall_request = LONG_HOLD;
        for (int i = 0; i < 24; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == 23);
        end
        no_gaps = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = 8'd0;
        in_ch.end_of_string = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.mode         = MODE_ENCODE;
        cur_mode            = MODE_RESET;
        clear_string_state();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_strict_decode();
        test_mode_write_clears();
        test_encode();
        test_lenient_decode();
        test_mode_three();
        test_random_strings();
        test_backpressure();

        // drain, then keep watching for anything stray to show up
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
